// ===== src/glzw_pkg.sv =====
// ----------------------------------------------------------------------------
// glzw_pkg
// shared types and constants of the gif lzw encoder
// ----------------------------------------------------------------------------
package glzw_pkg;

    localparam int MaxWidth   = 12;
    localparam int DictAbits  = 13;
    localparam int KeyW       = 20;
    localparam int TagW       = 4;
    localparam int HashW      = 29;

    // golden ratio multiplier, only the low bits up to the slot field matter
    localparam logic [HashW-1:0] HashMult = 29'h1E3779B1;
    localparam logic [12:0]      CodeLimit = 13'd4096;
    localparam logic [TagW-1:0]  TagMax    = 4'd15;
    localparam logic [TagW-1:0]  TagFirst  = 4'd1;

    typedef struct packed {
        logic [TagW-1:0]     tag;
        logic [KeyW-1:0]     key;
        logic [MaxWidth-1:0] code;
    } dict_entry_t;

    typedef struct packed {
        logic                valid;
        logic [MaxWidth-1:0] code;
        logic [3:0]          width;
        logic                fin;
    } code_req_t;

endpackage

// ===== src/glzw_dict_ram.sv =====
// ----------------------------------------------------------------------------
// glzw_dict_ram
// dictionary store, one write port and one registered read port
// ----------------------------------------------------------------------------
module glzw_dict_ram (
    input  logic                                clk,
    input  logic                                we,
    input  logic [glzw_pkg::DictAbits-1:0]      waddr,
    input  glzw_pkg::dict_entry_t               wdata,
    input  logic [glzw_pkg::DictAbits-1:0]      raddr,
    output glzw_pkg::dict_entry_t               rdata
);

    glzw_pkg::dict_entry_t mem [2**glzw_pkg::DictAbits];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/glzw_packer.sv =====
// ----------------------------------------------------------------------------
// glzw_packer
// packs codes lsb first into bytes and drives the output channel
// ----------------------------------------------------------------------------
module glzw_packer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  glzw_pkg::code_req_t   req,
    output logic                  req_ready,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            code_byte,
    output logic                  end_of_stream
);

    logic [23:0] buf_reg;
    logic [4:0]  cnt_reg;
    logic        fin_reg;
    logic [7:0]  byte_reg;
    logic        eos_reg;
    logic        ov_reg;

    logic        out_free;
    logic        drain;
    logic [11:0] masked;

    assign out_free  = !ov_reg || !out_stall;
    assign req_ready = (cnt_reg < 5'd8) && !fin_reg;
    assign drain     = out_free && ((cnt_reg >= 5'd8) || (fin_reg && (cnt_reg != 5'd0)));
    assign masked    = req.code & ~(12'hFFF << req.width);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '0;
            cnt_reg <= '0;
            fin_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (req.valid && req_ready)
            begin
                buf_reg <= buf_reg | (24'(masked) << cnt_reg);
                cnt_reg <= cnt_reg + 5'(req.width);
                fin_reg <= req.fin;
            end
            else if (drain)
            begin
                buf_reg <= buf_reg >> 8;
                cnt_reg <= (cnt_reg >= 5'd8) ? cnt_reg - 5'd8 : 5'd0;
                if (fin_reg && (cnt_reg <= 5'd8))
                begin
                    fin_reg <= 1'b0;
                end
            end
            if (drain)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_free)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            byte_reg <= buf_reg[7:0];
            eos_reg  <= fin_reg && (cnt_reg <= 5'd8);
        end
    end

    assign out_valid     = ov_reg;
    assign code_byte     = byte_reg;
    assign end_of_stream = eos_reg;

    // at most seven pending bits plus one widest code
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 5'd19)
        else $error("packer bit count overflow");

    // a pending flush always has bits left to send
    a_fin_bits: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> (cnt_reg != 5'd0))
        else $error("flush pending with empty buffer");

endmodule

// ===== src/gif_lzw_encoder_core.sv =====
// ----------------------------------------------------------------------------
// gif_lzw_encoder_core
// gif lzw encoder: palette indices in, packed variable width code bytes out
// ----------------------------------------------------------------------------
// One pixel index per input transaction, the final pixel of a frame flagged by
// last_pixel; out come the bytes of the lzw code stream, lsb first, with
// end_of_stream on the final byte of the frame. A frame opens with a clear code
// and closes with the pending prefix, the end code and a flush of the partial
// byte. Pixels are taken one at a time. A pixel is hashed, its slot is read
// from the dictionary ram and the entry compared; each further probe of the
// hashed dictionary repeats the read of the dictionary ram and the compare;
// each code sent adds a request to the packer plus a wait until the packer,
// which drains one byte a cycle while its output is not stalled, holds fewer
// than eight bits. After reset all 8192 entries of the dictionary ram are
// swept, and every fifteenth dictionary clear costs another sweep, during
// which no pixel is taken; configuration writes are taken at any time. The
// code size register lies at byte address 0 and is clamped to 2..8.
// ----------------------------------------------------------------------------
module gif_lzw_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel_index,
    input  logic        last_pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  code_byte,
    output logic        end_of_stream
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SWEEP = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_FIRST = 4'd5;
    localparam logic [3:0] S_PRE   = 4'd6;
    localparam logic [3:0] S_CLR   = 4'd7;
    localparam logic [3:0] S_FPRE  = 4'd8;
    localparam logic [3:0] S_FEND  = 4'd9;

    // configuration register
    logic [3:0]  mcs_reg;
    logic [3:0]  mcs;

    // control and state
    logic [3:0]  state_reg;
    logic [7:0]  pix_reg;
    logic        last_reg;
    logic [11:0] prefix_reg;
    logic [12:0] nfree_reg;
    logic [3:0]  width_reg;
    logic        in_stream_reg;
    logic [glzw_pkg::TagW-1:0]      epoch_reg;
    logic        sweep_pend_reg;
    logic [glzw_pkg::DictAbits-1:0] sweep_cnt_reg;
    logic [glzw_pkg::KeyW-1:0]      key_reg;
    logic [glzw_pkg::DictAbits-1:0] slot_reg;

    logic [7:0]  pix_in;
    logic [11:0] clr_code;
    logic [glzw_pkg::HashW-1:0] hash_prod;
    logic [12:0] nfree_inc;
    logic        insert_ok;

    // dictionary ram ports
    logic                           ram_we;
    logic [glzw_pkg::DictAbits-1:0] ram_waddr;
    glzw_pkg::dict_entry_t          ram_wdata;
    glzw_pkg::dict_entry_t          ram_rdata;
    logic                           hit_valid;

    glzw_pkg::code_req_t req;
    logic        req_ready;

    // clamp of the palette width
    assign mcs = (mcs_reg < 4'd2) ? 4'd2 : ((mcs_reg > 4'd8) ? 4'd8 : mcs_reg);

    // apb: single register, always ready
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, mcs_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcs_reg <= 4'd8;
        end
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            mcs_reg <= pwdata[3:0];
        end
    end

    assign pix_in     = pixel_index & ~(8'hFF << mcs);
    assign clr_code   = 12'd1 << mcs;
    assign hash_prod  = glzw_pkg::HashW'(key_reg) * glzw_pkg::HashMult;
    assign nfree_inc  = nfree_reg + 13'd1;
    assign insert_ok  = nfree_reg < glzw_pkg::CodeLimit;
    assign hit_valid  = (ram_rdata.tag == epoch_reg);
    assign in_stall   = (state_reg != S_IDLE) || sweep_pend_reg;

    // code requests towards the packer
    always_comb
    begin
        req.valid = 1'b0;
        req.code  = prefix_reg;
        req.width = width_reg;
        req.fin   = 1'b0;
        unique case (state_reg)
            S_FIRST, S_CLR:
            begin
                req.valid = 1'b1;
                req.code  = clr_code;
            end
            S_PRE, S_FPRE:
            begin
                req.valid = 1'b1;
            end
            S_FEND:
            begin
                req.valid = 1'b1;
                req.code  = clr_code + 12'd1;
                req.fin   = 1'b1;
            end
            default:
            begin
                req.valid = 1'b0;
            end
        endcase
    end

    // ram write: clearing sweep or a new string entry
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata.tag  = epoch_reg;
        ram_wdata.key  = key_reg;
        ram_wdata.code = nfree_reg[11:0];
        if (state_reg == S_SWEEP)
        begin
            ram_we        = 1'b1;
            ram_waddr     = sweep_cnt_reg;
            ram_wdata.tag = '0;
        end
        else if ((state_reg == S_PRE) && req_ready && insert_ok)
        begin
            ram_we = 1'b1;
        end
    end

    glzw_dict_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    glzw_packer u_packer (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .req_ready     (req_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_byte     (code_byte),
        .end_of_stream (end_of_stream)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            prefix_reg     <= '0;
            nfree_reg      <= 13'd258;
            width_reg      <= 4'd9;
            in_stream_reg  <= 1'b0;
            epoch_reg      <= glzw_pkg::TagFirst;
            sweep_pend_reg <= 1'b0;
            sweep_cnt_reg  <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (sweep_pend_reg)
                    begin
                        sweep_pend_reg <= 1'b0;
                        sweep_cnt_reg  <= '0;
                        state_reg      <= S_SWEEP;
                    end
                    else if (in_valid)
                    begin
                        last_reg <= last_pixel;
                        if (!in_stream_reg)
                        begin
                            // new frame: empty the dictionary
                            nfree_reg     <= 13'(clr_code) + 13'd2;
                            width_reg     <= mcs + 4'd1;
                            in_stream_reg <= 1'b1;
                            if (epoch_reg == glzw_pkg::TagMax)
                            begin
                                epoch_reg      <= glzw_pkg::TagFirst;
                                sweep_pend_reg <= 1'b1;
                            end
                            else
                            begin
                                epoch_reg <= epoch_reg + glzw_pkg::TagW'(1);
                            end
                            state_reg <= S_FIRST;
                        end
                        else
                        begin
                            state_reg <= S_HASH;
                        end
                        pix_reg <= pix_in;
                        key_reg <= {prefix_reg, pix_in};
                    end
                end
                S_SWEEP:
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + glzw_pkg::DictAbits'(1);
                    if (sweep_cnt_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_HASH:
                begin
                    slot_reg  <= hash_prod[glzw_pkg::HashW-1 -: glzw_pkg::DictAbits];
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (hit_valid && (ram_rdata.key == key_reg))
                    begin
                        prefix_reg <= ram_rdata.code;
                        state_reg  <= last_reg ? S_FPRE : S_IDLE;
                    end
                    else if (hit_valid)
                    begin
                        // linear probe to the next slot
                        slot_reg  <= slot_reg + glzw_pkg::DictAbits'(1);
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_PRE;
                    end
                end
                S_FIRST:
                begin
                    if (req_ready)
                    begin
                        prefix_reg <= 12'(pix_reg);
                        state_reg  <= last_reg ? S_FPRE : S_IDLE;
                    end
                end
                S_PRE:
                begin
                    if (req_ready)
                    begin
                        if (insert_ok)
                        begin
                            nfree_reg <= nfree_inc;
                            if ((nfree_inc > (13'd1 << width_reg)) &&
                                (width_reg < 4'(glzw_pkg::MaxWidth)))
                            begin
                                width_reg <= width_reg + 4'd1;
                            end
                            prefix_reg <= 12'(pix_reg);
                            state_reg  <= last_reg ? S_FPRE : S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_CLR;
                        end
                    end
                end
                S_CLR:
                begin
                    if (req_ready)
                    begin
                        nfree_reg <= 13'(clr_code) + 13'd2;
                        width_reg <= mcs + 4'd1;
                        if (epoch_reg == glzw_pkg::TagMax)
                        begin
                            epoch_reg      <= glzw_pkg::TagFirst;
                            sweep_pend_reg <= 1'b1;
                        end
                        else
                        begin
                            epoch_reg <= epoch_reg + glzw_pkg::TagW'(1);
                        end
                        prefix_reg <= 12'(pix_reg);
                        state_reg  <= last_reg ? S_FPRE : S_IDLE;
                    end
                end
                S_FPRE:
                begin
                    if (req_ready)
                    begin
                        if ((width_reg < 4'(glzw_pkg::MaxWidth)) &&
                            (nfree_reg == (13'd1 << width_reg)))
                        begin
                            width_reg <= width_reg + 4'd1;
                        end
                        state_reg <= S_FEND;
                    end
                end
                S_FEND:
                begin
                    if (req_ready)
                    begin
                        in_stream_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // code width stays within the gif limits
    a_width: assert property (@(posedge clk) disable iff (!rst_n)
        (width_reg >= 4'd3) && (width_reg <= 4'(glzw_pkg::MaxWidth)))
        else $error("code width out of range");

    // the code space never overflows
    a_nfree: assert property (@(posedge clk) disable iff (!rst_n)
        nfree_reg <= glzw_pkg::CodeLimit)
        else $error("next free code beyond limit");

    // the live epoch never equals the cleared tag
    a_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch collides with cleared tag");

    // a dictionary write only ever happens while sweeping or on a miss
    a_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_SWEEP) || ($past(state_reg) == S_CHECK) ||
                    ($past(state_reg) == S_PRE)))
        else $error("unexpected dictionary write");

endmodule

// ===== bench/gif_lzw_encoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// gif_lzw_encoder_core_tb
// self-checking bench for the gif lzw encoder core
// ----------------------------------------------------------------------------
// A stimulus table drives short frames first: single-pixel frames straight after
// reset, whose bytes are typed in, then code sizes two, five and eight with
// clamped register values, masked indices and code width growth. Random frames
// follow under several idling patterns.
// Every output byte is checked against an lzw encoder model held in the bench.
// ----------------------------------------------------------------------------
module gif_lzw_encoder_core_tb;

    localparam logic [2:0] MCS_ADDR = 3'd0;

    typedef enum logic [1:0] { ROW_PIXEL, ROW_PIXEL_TYPED, ROW_CONFIG } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [7:0] value;  // pixel index or register value
        logic       last;
        int         nbytes;
        logic [7:0] bytes [4];
    } stim_row_t;

    typedef struct {
        logic [7:0] data;
        logic       eos;
    } code_byte_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  pixel_index;
    logic        last_pixel;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  code_byte;
    logic        end_of_stream;

    // bytes still owed by the block, oldest first
    code_byte_t  pending_bytes [$];
    int          mismatches = 0;

    // idling knobs: percent of cycles idle or stalled, and a receiver hold-off
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles    = 0;

    // encoder model state
    logic [3:0]  mcs_reg;
    logic        in_frame;
    int unsigned prefix;
    int unsigned next_free;
    int unsigned cur_width;
    int unsigned bit_buf;
    int unsigned bit_cnt;
    int unsigned string_codes [int unsigned];

    gif_lzw_encoder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_index   (pixel_index),
        .last_pixel    (last_pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_byte     (code_byte),
        .end_of_stream (end_of_stream)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // encoder model
    // ------------------------------------------------------------------------

    // register value clamped to the legal palette sizes
    function automatic int unsigned code_bits();
        if (mcs_reg < 4'd2)
            return 2;
        if (mcs_reg > 4'd8)
            return 8;
        return 32'(mcs_reg);
    endfunction

    function automatic void empty_dictionary();
        string_codes.delete();
        next_free = (1 << code_bits()) + 2;
        cur_width = code_bits() + 1;
    endfunction

    // pack one code lsb first and queue every byte that completes
    function automatic void pack_code(int unsigned code, int unsigned width);
        int unsigned w;
        w = (width > glzw_pkg::MaxWidth) ? glzw_pkg::MaxWidth : width;
        bit_buf |= (code & ((1 << w) - 1)) << bit_cnt;
        bit_cnt += w;
        while (bit_cnt >= 8)
        begin
            pending_bytes.insert(pending_bytes.size(), '{data: bit_buf[7:0], eos: 1'b0});
            bit_buf >>= 8;
            bit_cnt -= 8;
        end
        bit_buf &= 32'hFF_FFFF;
    endfunction

    function automatic void predict_pixel(logic [7:0] pix_in, logic last);
        int unsigned m;
        int unsigned pix;
        int unsigned key;
        m   = code_bits();
        pix = pix_in & ((1 << m) - 1);
        if (!in_frame)
        begin
            // frame opens with a clear code
            empty_dictionary();
            pack_code(1 << m, cur_width);
            prefix   = pix;
            in_frame = 1'b1;
        end
        else
        begin
            key = ((prefix & 12'hFFF) << 8) | pix;
            if (string_codes.exists(key))
                prefix = string_codes[key];
            else
            begin
                pack_code(prefix, cur_width);
                if (next_free < (1 << glzw_pkg::MaxWidth))
                begin
                    string_codes[key] = next_free;
                    next_free++;
                    if (next_free > (1 << cur_width) && cur_width < glzw_pkg::MaxWidth)
                        cur_width++;
                end
                else
                begin
                    // dictionary full: clear code instead of a new entry
                    pack_code(1 << m, cur_width);
                    empty_dictionary();
                end
                prefix = pix;
            end
        end
        if (last)
        begin
            pack_code(prefix, cur_width);
            if (cur_width < glzw_pkg::MaxWidth && next_free == (1 << cur_width))
                cur_width++;
            pack_code((1 << m) + 1, cur_width);
            if (bit_cnt > 0)
                pending_bytes.insert(pending_bytes.size(),
                                     '{data: bit_buf[7:0], eos: 1'b0});
            bit_buf  = 0;
            bit_cnt  = 0;
            pending_bytes[$].eos = 1'b1;
            in_frame = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report(string what, int expd, int got);
        $display("MISMATCH at %0t: %s expected %0h got %0h", $realtime, what, expd, got);
        mismatches++;
    endtask

    // every byte the block hands over is matched against the oldest expectation
    always @(posedge clk)
    begin
        code_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
                report("unexpected byte", 0, code_byte);
            else
            begin
                want = pending_bytes.pop_front();
                if (code_byte !== want.data)
                    report("code_byte", want.data, code_byte);
                if (end_of_stream !== want.eos)
                    report("end_of_stream", want.eos, end_of_stream);
            end
        end
    end

    // receiver: random stalls, or a forced long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall   <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // offer one pixel, holding it until the block takes it
    task automatic send_pixel(logic [7:0] pix, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_index <= pix;
        last_pixel  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pixel(pix, last);
    endtask

    // wait for the last owed byte, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic write_mcs(logic [3:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= MCS_ADDR;
        pwdata  <= {28'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mcs_reg  = value;
        @(posedge clk);
    endtask

    // one frame of random pixels; a small alphabet makes strings repeat
    task automatic send_frame(int len, bit wide);
        logic [7:0] pix;
        int         alpha;
        alpha = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            if (wide || $urandom_range(9) == 0)
                pix = 8'($urandom_range(255));
            else
                pix = 8'($urandom_range(alpha));
            send_pixel(pix, i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------

    stim_row_t rows [] = '{
        // single-pixel frames right after reset, nine-bit codes
        '{ROW_PIXEL_TYPED, 8'd0,   1'b1, 4, '{8'h00, 8'h01, 8'h04, 8'h04}},
        '{ROW_PIXEL_TYPED, 8'd255, 1'b1, 4, '{8'h00, 8'hFF, 8'h05, 8'h04}},
        // two-bit palette: masked indices and width growth
        '{ROW_CONFIG, 8'd2,   1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd255, 1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd3,   1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd3,   1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd3,   1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd0,   1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd1,   1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd2,   1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd3,   1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd3,   1'b1, 0, '{default: 8'h0}},
        // register below range is taken as two
        '{ROW_CONFIG, 8'd0,   1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd6,   1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd2,   1'b1, 0, '{default: 8'h0}},
        // register above range is taken as eight
        '{ROW_CONFIG, 8'd15,  1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd128, 1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd128, 1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd128, 1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd128, 1'b1, 0, '{default: 8'h0}},
        '{ROW_CONFIG, 8'd5,   1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd31,  1'b0, 0, '{default: 8'h0}},
        '{ROW_PIXEL,  8'd0,   1'b1, 0, '{default: 8'h0}}
    };

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        int base;
        int sent;
        int budget;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        pixel_index = '0;
        last_pixel  = 1'b0;
        out_stall   = 1'b0;
        mcs_reg     = 4'd8;
        in_frame    = 1'b0;
        prefix      = 0;
        bit_buf     = 0;
        bit_cnt     = 0;
        empty_dictionary();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the table; typed rows are also held against the model
        foreach (rows[r])
        begin
            if (rows[r].kind == ROW_CONFIG)
            begin
                drain();
                write_mcs(rows[r].value[3:0]);
            end
            else
            begin
                send_pixel(rows[r].value, rows[r].last);
                if (rows[r].kind == ROW_PIXEL_TYPED)
                begin
                    // bytes of this transaction sit at the tail of the queue
                    base = pending_bytes.size() - rows[r].nbytes;
                    for (int b = 0; b < rows[r].nbytes; b++)
                        if (pending_bytes[base + b].data !== rows[r].bytes[b])
                            report("typed row", rows[r].bytes[b],
                                   pending_bytes[base + b].data);
                end
            end
        end
        drain();

        // random phases: none, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 15 : 65) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 15 : 65) : 0;
            if ($urandom_range(3) == 0)
                write_mcs(4'($urandom_range(15)));
            else
                write_mcs(4'($urandom_range(2, 8)));
            if (ph == 1)
            begin
                // receiver holds off while pixels keep coming, so the block backs up
                hold_cycles = 400;
                send_frame(60, 1'b0);
                drain();
            end
            sent = 0;
            while (sent < 55)
            begin
                budget = ($urandom_range(7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 20);
                send_frame(budget, 1'($urandom_range(1)));
                sent += budget;
                if ($urandom_range(3) == 0)
                begin
                    drain();
                    write_mcs(4'($urandom_range(15)));
                end
            end
            drain();
        end

        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
src/glzw_pkg.sv
src/glzw_dict_ram.sv
src/glzw_packer.sv
src/gif_lzw_encoder_core.sv
bench/gif_lzw_encoder_core_tb.sv
